>>> rtl/core/chacha_keystream_block_unit_defines.svh
// Assertion helpers shared by the keystream block RTL.
`ifndef CHACHA_KEYSTREAM_BLOCK_UNIT_DEFINES_SVH
`define CHACHA_KEYSTREAM_BLOCK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CKSB_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CKSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/cksb_pkg.sv
`timescale 1ns / 1ps

package cksb_pkg;

   // Field and datapath widths
   localparam int unsigned WORD_WIDTH          = 32;
   localparam int unsigned NUM_WORDS           = 16;
   localparam int unsigned COUNTER_WIDTH       = 64;
   localparam int unsigned CSR_DATA_WIDTH      = 64;
   localparam int unsigned CSR_INDEX_WIDTH     = 3;
   localparam int unsigned ROUND_COUNT_WIDTH   = 6;
   localparam int unsigned DOUBLE_ROUND_WIDTH  = 5;
   localparam int unsigned WORD_INDEX_WIDTH    = 4;
   localparam int unsigned WORD_COUNT_WIDTH    = 5;
   localparam int unsigned NUM_QR_UNITS        = 4;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_0       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_1       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_2       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_3       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONCE       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROUND_COUNT = 3'd5;

   localparam logic [ROUND_COUNT_WIDTH-1:0] ROUND_COUNT_RESET = 6'd20;

   typedef logic [WORD_WIDTH-1:0]    word_type;
   typedef word_type [NUM_WORDS-1:0] block_type;

   // "expand 32-byte k"
   localparam word_type SIGMA_0 = 32'h6170_7865;
   localparam word_type SIGMA_1 = 32'h3320_646e;
   localparam word_type SIGMA_2 = 32'h7962_2d32;
   localparam word_type SIGMA_3 = 32'h6b20_6574;

   // Quarter-round rotate amounts
   localparam int unsigned ROT_1 = 16;
   localparam int unsigned ROT_2 = 12;
   localparam int unsigned ROT_3 = 8;
   localparam int unsigned ROT_4 = 7;

   localparam logic [WORD_COUNT_WIDTH-1:0] FULL_COUNT = WORD_COUNT_WIDTH'(NUM_WORDS);
   localparam logic [WORD_INDEX_WIDTH-1:0] LAST_INDEX = WORD_INDEX_WIDTH'(NUM_WORDS - 1);

   typedef struct packed {
      logic [CSR_DATA_WIDTH-1:0]    key_0;
      logic [CSR_DATA_WIDTH-1:0]    key_1;
      logic [CSR_DATA_WIDTH-1:0]    key_2;
      logic [CSR_DATA_WIDTH-1:0]    key_3;
      logic [CSR_DATA_WIDTH-1:0]    nonce;
      logic [ROUND_COUNT_WIDTH-1:0] round_count;
   } cfg_type;

   // Head of the counter queue
   typedef struct packed {
      logic                     valid;
      logic [COUNTER_WIDTH-1:0] counter;
   } ctr_entry_type;

   // Finished block handed from the round engine to the output buffer
   typedef struct packed {
      logic      load;
      block_type words;
   } handoff_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } qr_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_COLUMN,
      RD_DIAG,
      RD_FINISH
   } round_state_type;

   function automatic word_type rotl(input word_type v, input int unsigned n);
      return (v << n) | (v >> (WORD_WIDTH - n));
   endfunction

   function automatic qr_type mix_quarter(input qr_type x);
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      qr_type   y;
      a = x.a;
      b = x.b;
      c = x.c;
      d = x.d;
      a = a + b; d = rotl(d ^ a, ROT_1);
      c = c + d; b = rotl(b ^ c, ROT_2);
      a = a + b; d = rotl(d ^ a, ROT_3);
      c = c + d; b = rotl(b ^ c, ROT_4);
      y.a = a;
      y.b = b;
      y.c = c;
      y.d = d;
      return y;
   endfunction

   // Initial state: constants, key, counter, nonce
   function automatic block_type init_state(input cfg_type cfg,
                                            input logic [COUNTER_WIDTH-1:0] ctr);
      block_type blk;
      blk[0]  = SIGMA_0;
      blk[1]  = SIGMA_1;
      blk[2]  = SIGMA_2;
      blk[3]  = SIGMA_3;
      blk[4]  = cfg.key_0[31:0];
      blk[5]  = cfg.key_0[63:32];
      blk[6]  = cfg.key_1[31:0];
      blk[7]  = cfg.key_1[63:32];
      blk[8]  = cfg.key_2[31:0];
      blk[9]  = cfg.key_2[63:32];
      blk[10] = cfg.key_3[31:0];
      blk[11] = cfg.key_3[63:32];
      blk[12] = ctr[63:32];
      blk[13] = ctr[31:0];
      blk[14] = cfg.nonce[63:32];
      blk[15] = cfg.nonce[31:0];
      return blk;
   endfunction

endpackage

>>> rtl/core/cksb_front.sv
`timescale 1ns / 1ps

module cksb_front #(
   parameter int unsigned DEPTH = cksb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic [cksb_pkg::COUNTER_WIDTH-1:0]   req_block_counter,
   output logic                                 req_full,
   output cksb_pkg::ctr_entry_type              head,
   input  logic                                 head_pop
);
   import cksb_pkg::*;

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR  = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_FILL = CNT_WIDTH'(DEPTH);

   logic [COUNTER_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]     fill_ff, fill_in;
   logic                     push_ok;
   logic                     pop_ok;

   // Transaction qualifiers
   assign req_full     = (fill_ff == FULL_FILL);
   assign push_ok      = req_push && !req_full;
   assign head.valid   = (fill_ff != '0);
   assign head.counter = entry_ff[rd_ptr_ff];
   assign pop_ok       = head_pop && head.valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Counter storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= req_block_counter;
      end
   end

endmodule

>>> rtl/core/cksb_rounds.sv
`timescale 1ns / 1ps
`include "chacha_keystream_block_unit_defines.svh"

module cksb_rounds (
   input  logic                    clock,
   input  logic                    reset,
   input  cksb_pkg::cfg_type       cfg,
   input  cksb_pkg::ctr_entry_type head,
   output logic                    head_pop,
   input  logic                    emit_ready,
   output cksb_pkg::handoff_type   handoff
);
   import cksb_pkg::*;

   round_state_type                state_ff, state_in;
   block_type                      work_ff, work_in;
   logic [COUNTER_WIDTH-1:0]       counter_ff, counter_in;
   logic [DOUBLE_ROUND_WIDTH-1:0]  dr_left_ff, dr_left_in;
   logic [DOUBLE_ROUND_WIDTH-1:0]  dr_load;
   block_type                      init_load;
   block_type                      init_final;
   block_type                      round_words;
   block_type                      final_words;
   logic                           diag;
   qr_type                         qr_in  [NUM_QR_UNITS];
   qr_type                         qr_out [NUM_QR_UNITS];

   assign dr_load    = cfg.round_count[ROUND_COUNT_WIDTH-1:1];
   assign init_load  = init_state(cfg, head.counter);
   assign init_final = init_state(cfg, counter_ff);
   assign diag       = (state_ff == RD_DIAG);

   // Four shared quarter-round units; operand routing picks column or diagonal
   for (genvar k = 0; k < NUM_QR_UNITS; k++) begin : g_qr
      localparam int unsigned B_DIAG = 4 + ((k + 1) & 3);
      localparam int unsigned C_DIAG = 8 + ((k + 2) & 3);
      localparam int unsigned D_DIAG = 12 + ((k + 3) & 3);
      assign qr_in[k].a = work_ff[k];
      assign qr_in[k].b = diag ? work_ff[B_DIAG] : work_ff[4 + k];
      assign qr_in[k].c = diag ? work_ff[C_DIAG] : work_ff[8 + k];
      assign qr_in[k].d = diag ? work_ff[D_DIAG] : work_ff[12 + k];
      assign qr_out[k]  = mix_quarter(qr_in[k]);
   end

   // Write quarter-round results back to the positions they came from
   always_comb begin
      round_words = work_ff;
      for (int k = 0; k < NUM_QR_UNITS; k++) begin
         round_words[k] = qr_out[k].a;
         if (diag) begin
            round_words[4 + ((k + 1) & 3)]  = qr_out[k].b;
            round_words[8 + ((k + 2) & 3)]  = qr_out[k].c;
            round_words[12 + ((k + 3) & 3)] = qr_out[k].d;
         end else begin
            round_words[4 + k]  = qr_out[k].b;
            round_words[8 + k]  = qr_out[k].c;
            round_words[12 + k] = qr_out[k].d;
         end
      end
   end

   // Feed-forward add of the initial state
   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         final_words[i] = work_ff[i] + init_final[i];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RD_IDLE: begin
            if (head.valid) begin
               state_in = (dr_load == '0) ? RD_FINISH : RD_COLUMN;
            end
         end
         RD_COLUMN: begin
            state_in = RD_DIAG;
         end
         RD_DIAG: begin
            state_in = (dr_left_ff == DOUBLE_ROUND_WIDTH'(1)) ? RD_FINISH : RD_COLUMN;
         end
         RD_FINISH: begin
            if (emit_ready) begin
               state_in = RD_IDLE;
            end
         end
         default: begin
            state_in = RD_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      head_pop      = 1'b0;
      work_in       = work_ff;
      counter_in    = counter_ff;
      dr_left_in    = dr_left_ff;
      handoff.load  = 1'b0;
      handoff.words = final_words;
      case (state_ff)
         RD_IDLE: begin
            head_pop = head.valid;
            if (head.valid) begin
               work_in    = init_load;
               counter_in = head.counter;
               dr_left_in = dr_load;
            end
         end
         RD_COLUMN: begin
            work_in = round_words;
         end
         RD_DIAG: begin
            work_in    = round_words;
            dr_left_in = dr_left_ff - 1'b1;
         end
         RD_FINISH: begin
            handoff.load = emit_ready;
         end
         default: begin
            head_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= RD_IDLE;
         dr_left_ff <= '0;
      end else begin
         state_ff   <= state_in;
         dr_left_ff <= dr_left_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      counter_ff <= counter_in;
   end

   // Checks
   `CKSB_ASSERT_IMPLIES(a_rounds_pending, clock, reset, (state_ff == RD_COLUMN || state_ff == RD_DIAG), (dr_left_ff != '0), "round engine running with no double rounds left")
   `CKSB_ASSERT_NEXT(a_handoff_to_idle, clock, reset, handoff.load, (state_ff == RD_IDLE), "round engine did not return to idle after handoff")

endmodule

>>> rtl/core/cksb_emit.sv
`timescale 1ns / 1ps
`include "chacha_keystream_block_unit_defines.svh"

module cksb_emit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cksb_pkg::handoff_type                 handoff,
   output logic                                  emit_ready,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [cksb_pkg::WORD_WIDTH-1:0]       rsp_keystream_word,
   output logic [cksb_pkg::WORD_INDEX_WIDTH-1:0] rsp_word_index,
   output logic                                  rsp_last_word
);
   import cksb_pkg::*;

   block_type                   words_ff, words_in;
   logic [WORD_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [WORD_INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                        pop_ok;

   // Result side: oldest word sits in slot zero
   assign emit_ready         = (count_ff == '0);
   assign rsp_empty          = (count_ff == '0);
   assign pop_ok             = rsp_pop && !rsp_empty;
   assign rsp_keystream_word = words_ff[0];
   assign rsp_word_index     = idx_ff;
   assign rsp_last_word      = (idx_ff == LAST_INDEX);

   // Load a whole block or shift one word out per transaction
   always_comb begin
      words_in = words_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (handoff.load) begin
         words_in = handoff.words;
         count_in = FULL_COUNT;
         idx_in   = '0;
      end else if (pop_ok) begin
         words_in = {WORD_WIDTH'(0), words_ff[NUM_WORDS-1:1]};
         count_in = count_ff - 1'b1;
         idx_in   = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   // Checks
   `CKSB_ASSERT_IMPLIES(a_load_when_empty, clock, reset, handoff.load, (count_ff == '0), "block loaded over undelivered words")
   `CKSB_ASSERT_IMPLIES(a_index_tracks_count, clock, reset, !rsp_empty, (({1'b0, idx_ff} + count_ff) == FULL_COUNT), "word index out of step with words left")

endmodule

>>> rtl/core/chacha_keystream_block_unit.sv
`timescale 1ns / 1ps

// ChaCha keystream block generator. Each transaction on the req_ side carries a
// 64-bit block counter; the block answers with 16 transactions on the rsp_ side,
// keystream words 0..15 of that block, with rsp_last_word set on word 15. Key,
// nonce and round count come from the csr_ registers (index 0..3 key bytes
// 0..31, 4 nonce, 5 round count, reset 20; odd counts round down, indexes above
// 5 are ignored) and must only change while no block is in flight. Counters
// wait in a small input queue; the round engine, with four quarter-round units,
// loads the initial state, runs a column round and a diagonal round per double
// round and then, once the output buffer is empty, hands the finished block to
// it. The output buffer drains one word per cycle while rsp_pop is held, and
// the engine can work on the next block while the buffer drains.
module chacha_keystream_block_unit #(
   parameter int unsigned QUEUE_DEPTH = cksb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input queue
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [cksb_pkg::COUNTER_WIDTH-1:0]    req_block_counter,
   // result queue
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [cksb_pkg::WORD_WIDTH-1:0]       rsp_keystream_word,
   output logic [cksb_pkg::WORD_INDEX_WIDTH-1:0] rsp_word_index,
   output logic                                  rsp_last_word,
   // register writes
   input  logic                                  csr_write_enable,
   input  logic [cksb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cksb_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import cksb_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   ctr_entry_type head;
   logic          head_pop;
   logic          emit_ready;
   handoff_type   handoff;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_KEY_0:       cfg_in.key_0       = csr_write_data;
            CSR_KEY_1:       cfg_in.key_1       = csr_write_data;
            CSR_KEY_2:       cfg_in.key_2       = csr_write_data;
            CSR_KEY_3:       cfg_in.key_3       = csr_write_data;
            CSR_NONCE:       cfg_in.nonce       = csr_write_data;
            CSR_ROUND_COUNT: cfg_in.round_count = csr_write_data[ROUND_COUNT_WIDTH-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{key_0: '0, key_1: '0, key_2: '0, key_3: '0, nonce: '0,
                    round_count: ROUND_COUNT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Counter queue
   cksb_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_block_counter (req_block_counter),
      .req_full          (req_full),
      .head              (head),
      .head_pop          (head_pop)
   );

   // Round engine
   cksb_rounds u_rounds (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .head_pop   (head_pop),
      .emit_ready (emit_ready),
      .handoff    (handoff)
   );

   // Output buffer
   cksb_emit u_emit (
      .clock              (clock),
      .reset              (reset),
      .handoff            (handoff),
      .emit_ready         (emit_ready),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

endmodule
